// File: rtl/core/maf_pkg.sv
// Package: shared widths, register indexes and command types of the moving average filter.
package maf_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int PRICE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int MODE_W     = 2;
  localparam int WLEN_W     = 9;
  localparam int WLEN_RESET = 20;

  localparam int PERIOD_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PROD_W   = PRICE_W + PERIOD_W;
  localparam int PSUM_W   = PRICE_W + PTR_W;
  localparam int WDIV_W   = 2 * PERIOD_W - 2;
  localparam int WSUM_W   = PRICE_W + WDIV_W;
  localparam int EMA_W    = PRICE_W + FRAC_W;
  localparam int DIV_W    = (EMA_W + 1 > WSUM_W) ? EMA_W + 1 : WSUM_W;
  localparam int DVSR_W   = (WDIV_W > PERIOD_W + 1) ? WDIV_W : PERIOD_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WLEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_MA_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = CFG_IDX_W'(1);

  localparam logic [MODE_W-1:0] MODE_SMA = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_EMA = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_WMA = MODE_W'(2);

  typedef enum logic [1:0] {
    KIND_SMA,
    KIND_EMA,
    KIND_WMA
  } kind_e;

  typedef struct packed {
    logic [PRICE_W-1:0]  price;
    logic                clear;
    kind_e               kind;
    logic [PERIOD_W-1:0] period;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_stat_t;

endpackage

// File: rtl/core/maf_intf.sv
// Interfaces: sample, result and configuration channels of the moving average filter.
interface maf_in_if
  import maf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] close_price;
  logic               restart;

  modport source (output valid, output close_price, output restart, input ready);
  modport sink   (input valid, input close_price, input restart, output ready);
endinterface

interface maf_out_if
  import maf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

interface maf_cfg_if
  import maf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/maf_front.sv
// Front end: configuration registers and classification of incoming samples into commands.
module maf_front
  import maf_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  maf_in_if.sink         sample_i,
  maf_cfg_if.sink        cfg_i,
  output logic           cmd_valid_o,
  output cmd_t           cmd_o,
  input  logic           cmd_ready_i
);

  logic [MODE_W-1:0]   mode_q;
  logic [WLEN_W-1:0]   wlen_q;
  logic                dirty_q;
  logic [PERIOD_W-1:0] period;
  kind_e               kind;
  logic                accept;

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = cmd_ready_i;
  assign cmd_valid_o    = sample_i.valid;
  assign accept         = sample_i.valid && cmd_ready_i;

  // clamp the period into 1 .. MAX_WINDOW
  always_comb begin
    if (wlen_q == '0) begin
      period = PERIOD_W'(1);
    end else if (32'(wlen_q) > 32'(MAX_WINDOW)) begin
      period = PERIOD_W'(MAX_WINDOW);
    end else begin
      period = PERIOD_W'(wlen_q);
    end
  end

  always_comb begin
    unique case (mode_q)
      MODE_EMA: kind = KIND_EMA;
      MODE_WMA: kind = KIND_WMA;
      default:  kind = KIND_SMA;
    endcase
  end

  always_comb begin
    cmd_o.price  = sample_i.close_price;
    cmd_o.clear  = sample_i.restart || dirty_q;
    cmd_o.kind   = kind;
    cmd_o.period = period;
  end

  // a write to the mode or window register drops all history before the next sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SMA;
      wlen_q  <= WLEN_W'(WLEN_RESET);
      dirty_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.index == REG_MA_MODE) begin
        mode_q  <= cfg_i.data[MODE_W-1:0];
        dirty_q <= 1'b1;
      end else if (cfg_i.valid && cfg_i.index == REG_WINDOW) begin
        wlen_q  <= cfg_i.data[WLEN_W-1:0];
        dirty_q <= 1'b1;
      end else if (accept) begin
        dirty_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/maf_queue.sv
// Two-entry command queue between the front end and the arithmetic back end.
module maf_queue
  import maf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  localparam int QD     = 2;
  localparam int QPTR_W = $clog2(QD);
  localparam int QCNT_W = $clog2(QD + 1);

  cmd_t              entry_q [QD];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push;
  logic              pop;

  assign push_ready_o = count_q != QCNT_W'(QD);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QD - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QD - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/maf_div.sv
// Restoring divider: one quotient bit per cycle.
module maf_div
  import maf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_req_t  req_i,
  output div_stat_t stat_o
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DVSR_W-1:0] rem_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DVSR_W-1:0] dvsr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DVSR_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvsr_q};

  assign stat_o.busy     = busy_q;
  assign stat_o.done     = done_q;
  assign stat_o.quotient = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q  <= '0;
      quo_q  <= req_i.dividend;
      dvsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= fits ? DVSR_W'(trial - {1'b0, dvsr_q}) : trial[DVSR_W-1:0];
      quo_q  <= {quo_q[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        cnt_q  <= CNT_W'(DIV_W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

endmodule

// File: rtl/core/maf_back.sv
// Back end: sample ring, running sums, EMA update and result register.
module maf_back
  import maf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_ready_o,
  output div_req_t   div_req_o,
  input  div_stat_t  div_stat_i,
  maf_out_if.source  avg_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMA,
    S_RD,
    S_UPD,
    S_CHK,
    S_DIV,
    S_OUT
  } state_e;

  localparam int TRI_W = 2 * PERIOD_W;

  state_e              state_q;
  cmd_t                cmd_q;
  logic [PRICE_W-1:0]  ring_q [MAX_WINDOW];
  logic [PRICE_W-1:0]  oldest_q;
  logic [PTR_W-1:0]    ptr_q;
  logic [PERIOD_W-1:0] fill_q;
  logic [PSUM_W-1:0]   psum_q;
  logic [WSUM_W-1:0]   wsum_q;
  logic [EMA_W-1:0]    ema_q;
  logic                up_q;
  logic [PROD_W-1:0]   prod_q;
  logic [WDIV_W-1:0]   tri_q;
  logic [PRICE_W-1:0]  res_q;
  logic [PRICE_W-1:0]  avg_q;
  logic                out_valid_q;

  logic                growing;
  logic [PERIOD_W-1:0] factor;
  logic [TRI_W-1:0]    tri_full;
  logic [EMA_W-1:0]    target;
  logic                ema_up;
  logic [EMA_W-1:0]    ema_diff;
  logic [EMA_W-1:0]    step;
  logic [EMA_W-1:0]    ema_new;
  logic [PTR_W:0]      ptr_inc;
  logic                load_out;

  assign cmd_ready_o = state_q == S_IDLE;
  assign avg_o.valid   = out_valid_q;
  assign avg_o.average = avg_q;
  assign load_out      = !out_valid_q || avg_o.ready;

  assign growing  = fill_q < cmd_q.period;
  assign factor   = growing ? fill_q + PERIOD_W'(1) : cmd_q.period;
  assign tri_full = TRI_W'(cmd_q.period) * TRI_W'(cmd_q.period + PERIOD_W'(1));
  assign target   = {cmd_q.price, FRAC_W'(0)};
  assign ema_up   = target >= ema_q;
  assign ema_diff = ema_up ? target - ema_q : ema_q - target;
  assign step     = div_stat_i.quotient[EMA_W-1:0];
  assign ema_new  = up_q ? ema_q + step : ema_q - step;
  assign ptr_inc  = {1'b0, ptr_q} + (PTR_W + 1)'(1);

  // divider operands per kind
  always_comb begin
    div_req_o.start = (state_q == S_EMA && fill_q != '0) || (state_q == S_CHK && !growing);
    unique case (cmd_q.kind)
      KIND_EMA: begin
        div_req_o.dividend = DIV_W'({ema_diff, 1'b0});
        div_req_o.divisor  = DVSR_W'(cmd_q.period) + DVSR_W'(1);
      end
      KIND_WMA: begin
        div_req_o.dividend = DIV_W'(wsum_q);
        div_req_o.divisor  = DVSR_W'(tri_q);
      end
      default: begin
        div_req_o.dividend = DIV_W'(psum_q);
        div_req_o.divisor  = DVSR_W'(cmd_q.period);
      end
    endcase
  end

  // sample ring, read in the cycle before the slot is overwritten
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      oldest_q <= ring_q[ptr_q];
    end
    if (state_q == S_UPD) begin
      ring_q[ptr_q] <= cmd_q.price;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      ptr_q       <= '0;
      fill_q      <= '0;
      psum_q      <= '0;
      wsum_q      <= '0;
      ema_q       <= '0;
      up_q        <= 1'b0;
      prod_q      <= '0;
      tri_q       <= '0;
      res_q       <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (avg_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            if (cmd_i.clear) begin
              ptr_q  <= '0;
              fill_q <= '0;
              psum_q <= '0;
              wsum_q <= '0;
              ema_q  <= '0;
            end
            state_q <= (cmd_i.kind == KIND_EMA) ? S_EMA : S_RD;
          end
        end
        S_EMA: begin
          if (fill_q == '0) begin
            // seed from the first sample
            ema_q   <= target;
            fill_q  <= PERIOD_W'(1);
            res_q   <= cmd_q.price;
            state_q <= S_OUT;
          end else begin
            up_q    <= ema_up;
            state_q <= S_DIV;
          end
        end
        S_RD: begin
          prod_q  <= PROD_W'(factor) * PROD_W'(cmd_q.price);
          tri_q   <= tri_full[WDIV_W:1];
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (growing) begin
            wsum_q <= wsum_q + WSUM_W'(prod_q);
            psum_q <= psum_q + PSUM_W'(cmd_q.price);
            fill_q <= fill_q + PERIOD_W'(1);
          end else begin
            wsum_q <= wsum_q + WSUM_W'(prod_q) - WSUM_W'(psum_q);
            psum_q <= psum_q + PSUM_W'(cmd_q.price) - PSUM_W'(oldest_q);
          end
          ptr_q   <= (ptr_inc >= (PTR_W + 1)'(cmd_q.period)) ? '0 : ptr_inc[PTR_W-1:0];
          state_q <= S_CHK;
        end
        S_CHK: begin
          // drop the item while the window is still filling
          state_q <= growing ? S_IDLE : S_DIV;
        end
        S_DIV: begin
          if (div_stat_i.done) begin
            if (cmd_q.kind == KIND_EMA) begin
              ema_q <= ema_new;
              res_q <= ema_new[EMA_W-1:FRAC_W];
            end else begin
              res_q <= div_stat_i.quotient[PRICE_W-1:0];
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            avg_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_stat_i.busy || div_stat_i.done))
    else $error("back end waits on an idle divider");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> ((PTR_W + 1)'(ptr_q) < (PTR_W + 1)'(cmd_q.period)))
    else $error("ring pointer outside the period");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> (fill_q <= cmd_q.period))
    else $error("fill count beyond the period");
`endif

endmodule

// File: rtl/core/moving_average_filter_core.sv
// Top level: moving average filter core (front end, command queue, back end, divider).
//
// Usage:
//   sample_i carries one price sample (close_price) with a restart flag that
//   drops all history before the sample is taken. avg_o returns at most one
//   average per sample: simple and weighted averages appear only once the
//   window holds N samples; the exponential average appears for every sample.
//   cfg_i writes ma_mode (index 0) or window_length (index 1); either write
//   drops the history ahead of the next sample. cfg_i is always ready.
// Operation:
//   The back end works on one sample at a time and takes no new sample before it is
//   through with the last one. The simple and weighted averages, and every
//   exponential sample but the first after a clear, pass through the 49-step
//   restoring divider. A window-filling sample with no result holds the back end
//   through the read, update and check states.
// Reset: mode simple, period 20, all sums and counts cleared; the sample ring
//   is not cleared, only slots written since the last clear are read.
// Stall: a finished average waits in the output register; the back end holds
//   and the two-entry command queue takes further samples until it fills.
module moving_average_filter_core
  import maf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  maf_in_if.sink    sample_i,
  maf_cfg_if.sink   cfg_i,
  maf_out_if.source avg_o
);

  logic      push_valid;
  cmd_t      push_cmd;
  logic      push_ready;
  logic      pop_valid;
  cmd_t      pop_cmd;
  logic      pop_ready;
  div_req_t  div_req;
  div_stat_t div_stat;

  maf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .cfg_i       (cfg_i),
    .cmd_valid_o (push_valid),
    .cmd_o       (push_cmd),
    .cmd_ready_i (push_ready)
  );

  maf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  maf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_ready_o (pop_ready),
    .div_req_o   (div_req),
    .div_stat_i  (div_stat),
    .avg_o       (avg_o)
  );

  maf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat)
  );

endmodule

// File: dv/moving_average_filter_checker.sv
// Checker: watches the sample, register and average channels, predicts each average and compares.
module moving_average_filter_checker
  import maf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  maf_in_if           sample_mon,
  maf_cfg_if          cfg_mon,
  maf_out_if          avg_mon,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned averages_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [MODE_W-1:0]   mode_q;
  logic [WLEN_W-1:0]   wlen_q;
  logic [PRICE_W-1:0]  price_ring [MAX_WINDOW];
  logic [PTR_W-1:0]    slot_q;
  logic [PERIOD_W-1:0] filled_q;
  logic [PSUM_W-1:0]   plain_sum_q;
  logic [WSUM_W-1:0]   weighted_sum_q;
  logic [EMA_W-1:0]    ema_q;

  logic [PRICE_W-1:0] avg_expected [$];
  int unsigned mismatch_count = 0;
  int unsigned waiting_count = 0;
  int unsigned checked_count = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = waiting_count;
  assign averages_o   = checked_count;

  task automatic report(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  // The ring itself is left alone: only slots written since the clear are read.
  task automatic drop_history();
    slot_q         = '0;
    filled_q       = '0;
    plain_sum_q    = '0;
    weighted_sum_q = '0;
    ema_q          = '0;
  endtask

  function automatic logic [63:0] window_period(input logic [WLEN_W-1:0] w);
    if (w == '0) return 64'd1;
    if (w > MAX_WINDOW) return 64'(MAX_WINDOW);
    return 64'(w);
  endfunction

  task automatic take_sample(input logic [PRICE_W-1:0] price, input logic restart);
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] target;
    logic [63:0] delta;
    logic [63:0] oldest;
    x = 64'(price);
    n = window_period(wlen_q);
    if (restart) drop_history();
    if (mode_q == MODE_EMA) begin
      target = x << FRAC_W;
      if (filled_q == '0) begin
        ema_q    = EMA_W'(target);
        filled_q = PERIOD_W'(1);
      end else if (target >= 64'(ema_q)) begin
        delta = target - 64'(ema_q);
        ema_q = EMA_W'(64'(ema_q) + (2 * delta) / (n + 1));
      end else begin
        delta = 64'(ema_q) - target;
        ema_q = EMA_W'(64'(ema_q) - (2 * delta) / (n + 1));
      end
      avg_expected.push_back(PRICE_W'(ema_q >> FRAC_W));
    end else begin
      if (64'(filled_q) < n) begin
        // growing window: older samples keep their weights
        weighted_sum_q = WSUM_W'(64'(weighted_sum_q) + (64'(filled_q) + 1) * x);
        plain_sum_q    = PSUM_W'(64'(plain_sum_q) + x);
        filled_q       = filled_q + 1'b1;
      end else begin
        oldest         = 64'(price_ring[slot_q]);
        weighted_sum_q = WSUM_W'(64'(weighted_sum_q) + n * x - 64'(plain_sum_q));
        plain_sum_q    = PSUM_W'(64'(plain_sum_q) + x - oldest);
      end
      price_ring[slot_q] = price;
      if (64'(slot_q) + 1 >= n) slot_q = '0;
      else slot_q = slot_q + 1'b1;
      if (64'(filled_q) >= n) begin
        if (mode_q == MODE_WMA) begin
          avg_expected.push_back(PRICE_W'(64'(weighted_sum_q) / (n * (n + 1) / 2)));
        end else begin
          avg_expected.push_back(PRICE_W'(64'(plain_sum_q) / n));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [PRICE_W-1:0] want;
    if (!rst_ni) begin
      mode_q = MODE_SMA;
      wlen_q = WLEN_W'(WLEN_RESET);
      drop_history();
      avg_expected.delete();
      waiting_count = 0;
    end else begin
      // compare before taking new requests: a sample never yields an average in its own cycle
      if (avg_mon.valid && avg_mon.ready) begin
        if (avg_expected.size() == 0) begin
          report($sformatf("average %0d arrived with none expected", avg_mon.average));
        end else begin
          want = avg_expected.pop_front();
          checked_count++;
          if (avg_mon.average !== want) begin
            report($sformatf("average %0d, expected %0d", avg_mon.average, want));
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_MA_MODE) begin
          mode_q = cfg_mon.data[MODE_W-1:0];
          drop_history();
        end else if (cfg_mon.index == REG_WINDOW) begin
          wlen_q = cfg_mon.data[WLEN_W-1:0];
          drop_history();
        end
      end
      if (sample_mon.valid && sample_mon.ready) begin
        take_sample(sample_mon.close_price, sample_mon.restart);
      end
      waiting_count = avg_expected.size();
    end
  end

endmodule

// File: dv/moving_average_filter_core_test.sv
// Testbench top: drives samples and register writes into the moving average filter and gives the verdict.
module moving_average_filter_core_test
  import maf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned QUIET_CYCLES = 200;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam logic [PRICE_W-1:0]   PRICE_MAX     = '1;
  localparam logic [MODE_W-1:0]    MODE_SPARE    = MODE_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(3);

  logic clk_i;
  logic rst_ni;

  maf_in_if  sample_if ();
  maf_cfg_if cfg_if ();
  maf_out_if avg_if ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned averages;
  int unsigned sent_count = 0;
  int unsigned write_count = 0;
  int unsigned setting_count = 0;

  moving_average_filter_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .cfg_i    (cfg_if),
    .avg_o    (avg_if)
  );

  moving_average_filter_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_mon   (sample_if),
    .cfg_mon      (cfg_if),
    .avg_mon      (avg_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .averages_o   (averages)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(30_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [PRICE_W-1:0] pick_price();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PRICE_MAX;
      2: return PRICE_W'($urandom_range(0, 255));
      3: return PRICE_MAX - PRICE_W'($urandom_range(0, 1000));
      default: return PRICE_W'($urandom);
    endcase
  endfunction

  // hold the request until the register port takes it; the caller lowers valid
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    write_count++;
  endtask

  task automatic end_writes();
    cfg_if.valid <= 1'b0;
    setting_count++;
  endtask

  task automatic send(input logic [PRICE_W-1:0] price, input logic restart, input int unsigned gap);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid       <= 1'b1;
    sample_if.close_price <= price;
    sample_if.restart     <= restart;
    do @(posedge clk_i); while (!sample_if.ready);
    sent_count++;
  endtask

  // drop valid, wait for every average, then let any sample without one finish
  task automatic settle();
    int unsigned guard;
    guard = 0;
    sample_if.valid <= 1'b0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // result side: short bursts of ready with random stalls, sometimes a long free run
  initial begin
    int unsigned stall;
    avg_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      avg_if.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 300)) @(posedge clk_i);
      else repeat ($urandom_range(1, 8)) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        avg_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [MODE_W-1:0] mode;
    int unsigned wlen;
    int unsigned period;
    int unsigned items;
    int unsigned r;
    bit steady;

    rst_ni                <= 1'b0;
    sample_if.valid       <= 1'b0;
    sample_if.close_price <= '0;
    sample_if.restart     <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= REG_MA_MODE;
    cfg_if.data           <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // exponential with a zero period, which acts as one
    write_reg(REG_MA_MODE, CFG_DATA_W'(MODE_EMA));
    write_reg(REG_WINDOW, '0);
    end_writes();
    send('0, 1'b0, pick_gap());
    send(PRICE_MAX, 1'b0, pick_gap());
    send(PRICE_MAX, 1'b0, pick_gap());
    send('0, 1'b0, pick_gap());
    send(PRICE_W'(12345), 1'b1, pick_gap());
    settle();

    // the spare mode code behaves as simple
    write_reg(REG_MA_MODE, CFG_DATA_W'(MODE_SPARE));
    write_reg(REG_WINDOW, CFG_DATA_W'(2));
    end_writes();
    send(PRICE_MAX, 1'b0, pick_gap());
    send(PRICE_MAX, 1'b0, pick_gap());
    send('0, 1'b0, pick_gap());
    send(PRICE_W'(1), 1'b1, pick_gap());
    send(PRICE_MAX, 1'b0, pick_gap());
    settle();

    write_reg(REG_MA_MODE, CFG_DATA_W'(MODE_WMA));
    write_reg(REG_WINDOW, CFG_DATA_W'(3));
    end_writes();
    send(PRICE_MAX, 1'b0, pick_gap());
    send(PRICE_MAX, 1'b0, pick_gap());
    send(PRICE_MAX, 1'b0, pick_gap());
    send('0, 1'b0, pick_gap());
    send(PRICE_W'(7), 1'b0, pick_gap());
    settle();

    // writes past the register list must leave the history alone
    write_reg(REG_UNUSED_LO, '1);
    write_reg(REG_UNUSED_HI, '0);
    end_writes();
    send(PRICE_W'(100), 1'b0, pick_gap());
    send(PRICE_MAX, 1'b1, pick_gap());
    settle();

    // oversize period clamps to the ring size
    write_reg(REG_MA_MODE, CFG_DATA_W'(MODE_EMA));
    write_reg(REG_WINDOW, '1);
    end_writes();
    mode = MODE_EMA;
    wlen = (1 << WLEN_W) - 1;
    send(PRICE_MAX, 1'b0, pick_gap());
    send('0, 1'b0, pick_gap());
    send(PRICE_MAX, 1'b0, pick_gap());
    settle();

    while (sent_count < RANDOM_ITEMS + 20) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, CFG_DATA_W'($urandom));
      end
      if (r == 1 || r >= 3) begin
        mode = MODE_W'($urandom_range(0, 3));
        write_reg(REG_MA_MODE, CFG_DATA_W'(mode));
      end
      if (r >= 2) begin
        r = $urandom_range(0, 99);
        if (r < 70) wlen = $urandom_range(1, 16);
        else if (r < 80) wlen = $urandom_range(17, 64);
        else if (r < 85) wlen = 0;
        else if (r < 89) wlen = MAX_WINDOW;
        else if (r < 92) wlen = $urandom_range(MAX_WINDOW + 1, (1 << WLEN_W) - 1);
        else wlen = $urandom_range(65, MAX_WINDOW - 1);
        write_reg(REG_WINDOW, CFG_DATA_W'(wlen));
      end
      end_writes();
      period = (wlen == 0) ? 1 : ((wlen > MAX_WINDOW) ? MAX_WINDOW : wlen);
      items  = period + $urandom_range(4, 40);
      steady = ($urandom_range(0, 5) == 0);
      repeat (items) begin
        send(pick_price(), ($urandom_range(0, 39) == 0), steady ? 0 : pick_gap());
      end
      settle();
    end

    $display("Run covered %0d samples over %0d settings with %0d register writes.",
             sent_count, setting_count, write_count);
    $display("%0d averages checked, %0d still awaited.", averages, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/maf_pkg.sv
rtl/core/maf_intf.sv
rtl/core/maf_front.sv
rtl/core/maf_queue.sv
rtl/core/maf_div.sv
rtl/core/maf_back.sv
rtl/core/moving_average_filter_core.sv
dv/moving_average_filter_checker.sv
dv/moving_average_filter_core_test.sv
